@@ hdl/dbd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared constants, types and calendar helpers of the days-between-dates block.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int unsigned YEAR_BITS  = 12;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned COUNT_BITS = 21;
  localparam int unsigned DOY_BITS   = 9;
  // Wide enough for the sum of all year lengths below the largest year.
  localparam int unsigned ACC_BITS   = YEAR_BITS + DOY_BITS;
  localparam int unsigned DIFF_BITS  = ACC_BITS + 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [DOY_BITS-1:0] doy_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  localparam doy_t MONTH_OFFSET [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Day of year; months below January or above December are clamped.
  function automatic doy_t day_of_year(input logic leap,
                                       input logic [MONTH_BITS-1:0] month,
                                       input logic [DAY_BITS-1:0] day);
    logic [MONTH_BITS-1:0] m;
    doy_t                  doy;
    m = month;
    if (m < MONTH_BITS'(1)) begin
      m = MONTH_BITS'(1);
    end
    if (m > MONTH_BITS'(12)) begin
      m = MONTH_BITS'(12);
    end
    doy = MONTH_OFFSET[m - MONTH_BITS'(1)] + DOY_BITS'(day);
    if (m > MONTH_BITS'(2) && leap) begin
      doy = doy + DOY_BITS'(1);
    end
    return doy;
  endfunction

endpackage

@@ hdl/days_between_dates.sv @@
// ----------------------------------------------------------------------------
// days_between_dates
// Gregorian day count from a start date to an end date.
// ----------------------------------------------------------------------------
// After an input transfer the block sweeps the years from 0 up to the end
// year, one year per cycle, through a single accumulating adder; the lengths
// of the years from the start year up to the year before the end year are
// summed, and the leap flags of both years are picked up on the way from
// running mod-100 and mod-400 counters. A finishing state then adds the end
// day of year and subtracts the start day of year. The result is offered once
// that state is done, or in the cycle right after the input transfer when
// the start year is above the end year.
// The input is not ready again until the result has been transferred, so the
// block does not take a new item before it is through with the last one.
module days_between_dates (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dbd_pkg::YEAR_BITS-1:0]     from_year_i,
  input  logic [dbd_pkg::MONTH_BITS-1:0]    from_month_i,
  input  logic [dbd_pkg::DAY_BITS-1:0]      from_day_i,
  input  logic [dbd_pkg::YEAR_BITS-1:0]     to_year_i,
  input  logic [dbd_pkg::MONTH_BITS-1:0]    to_month_i,
  input  logic [dbd_pkg::DAY_BITS-1:0]      to_day_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dbd_pkg::COUNT_BITS-1:0]    day_count_o,
  output logic                              date_order_ok_o
);

  dbd_pkg::state_e                     state_q, state_d;
  logic [dbd_pkg::YEAR_BITS-1:0]       from_year_q, to_year_q, year_q;
  logic [dbd_pkg::MONTH_BITS-1:0]      from_month_q, to_month_q;
  logic [dbd_pkg::DAY_BITS-1:0]        from_day_q, to_day_q;
  logic [6:0]                          mod100_q;
  logic [8:0]                          mod400_q;
  logic [dbd_pkg::ACC_BITS-1:0]        acc_q;
  logic                                leap_from_q, leap_to_q;
  logic [dbd_pkg::COUNT_BITS-1:0]      count_q;
  logic                                ok_q;

  logic                                in_xfer, leap;
  dbd_pkg::doy_t                       doy_from, doy_to;
  logic signed [dbd_pkg::DIFF_BITS-1:0] diff;

  assign in_xfer  = in_valid_i && in_ready_o;

  assign in_ready_o      = (state_q == dbd_pkg::ST_IDLE);
  assign out_valid_o     = (state_q == dbd_pkg::ST_DONE);
  assign day_count_o     = count_q;
  assign date_order_ok_o = ok_q;

  assign leap = (year_q[1:0] == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

  assign doy_from = dbd_pkg::day_of_year(leap_from_q, from_month_q, from_day_q);
  assign doy_to   = dbd_pkg::day_of_year(leap_to_q, to_month_q, to_day_q);
  assign diff = $signed({2'b00, acc_q})
              + $signed(dbd_pkg::DIFF_BITS'(doy_to))
              - $signed(dbd_pkg::DIFF_BITS'(doy_from));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (from_year_i > to_year_i) ? dbd_pkg::ST_DONE : dbd_pkg::ST_SWEEP;
        end
      end
      dbd_pkg::ST_SWEEP: begin
        if (year_q == to_year_q) begin
          state_d = dbd_pkg::ST_FINISH;
        end
      end
      dbd_pkg::ST_FINISH: state_d = dbd_pkg::ST_DONE;
      dbd_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = dbd_pkg::ST_IDLE;
        end
      end
      default: state_d = dbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      from_year_q  <= from_year_i;
      from_month_q <= from_month_i;
      from_day_q   <= from_day_i;
      to_year_q    <= to_year_i;
      to_month_q   <= to_month_i;
      to_day_q     <= to_day_i;
      year_q       <= '0;
      mod100_q     <= '0;
      mod400_q     <= '0;
      acc_q        <= '0;
      count_q      <= '0;
      ok_q         <= 1'b0;
    end else if (state_q == dbd_pkg::ST_SWEEP) begin
      if (year_q == from_year_q) begin
        leap_from_q <= leap;
      end
      if (year_q == to_year_q) begin
        leap_to_q <= leap;
      end else if (year_q >= from_year_q) begin
        acc_q <= acc_q + dbd_pkg::ACC_BITS'(365) + dbd_pkg::ACC_BITS'(leap);
      end
      year_q   <= year_q + dbd_pkg::YEAR_BITS'(1);
      mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 7'd1;
      mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end else if (state_q == dbd_pkg::ST_FINISH) begin
      if (diff < 0) begin
        count_q <= '0;
        ok_q    <= 1'b0;
      end else begin
        if (diff > $signed(dbd_pkg::DIFF_BITS'(dbd_pkg::COUNT_MAX))) begin
          count_q <= dbd_pkg::COUNT_MAX;
        end else begin
          count_q <= diff[dbd_pkg::COUNT_BITS-1:0];
        end
        ok_q <= 1'b1;
      end
    end
  end

  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_order_ok_o) |-> (day_count_o == '0))
    else $error("error result with nonzero count");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbd_pkg::ST_SWEEP) |-> (year_q <= to_year_q))
    else $error("year sweep ran past the end year");

  a_order_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (from_year_i > to_year_i)) |=> (out_valid_o && !date_order_ok_o))
    else $error("start year after end year not reported as error");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(day_count_o)))
    else $error("offered result changed before its transfer");

endmodule

@@ bench/dbd_span_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbd_span_checker
// Watches both channels of the days-between-dates block, computes the day span
// of every accepted date pair and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module dbd_span_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [dbd_pkg::YEAR_BITS-1:0]     from_year_i,
  input  logic [dbd_pkg::MONTH_BITS-1:0]    from_month_i,
  input  logic [dbd_pkg::DAY_BITS-1:0]      from_day_i,
  input  logic [dbd_pkg::YEAR_BITS-1:0]     to_year_i,
  input  logic [dbd_pkg::MONTH_BITS-1:0]    to_month_i,
  input  logic [dbd_pkg::DAY_BITS-1:0]      to_day_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [dbd_pkg::COUNT_BITS-1:0]    day_count_i,
  input  logic                              date_order_ok_i,
  output int                                err_cnt_o,
  output int                                pend_cnt_o
);

  typedef logic [dbd_pkg::YEAR_BITS-1:0]  year_t;
  typedef logic [dbd_pkg::MONTH_BITS-1:0] month_t;
  typedef logic [dbd_pkg::DAY_BITS-1:0]   mday_t;
  typedef logic [dbd_pkg::COUNT_BITS-1:0] count_t;

  typedef struct packed {
    count_t count;
    logic   ok;
  } span_t;

  // Days in all months before the given one, for a common year.
  localparam int unsigned CUM_DAYS [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  span_t span_q [$];

  // Days from the start of year 0 to the start of year y.
  function automatic longint unsigned days_to_year(year_t y);
    longint unsigned n;
    n = y;
    return 365 * n + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
  endfunction

  function automatic longint unsigned year_day(year_t y, month_t m, mday_t d);
    int unsigned mo;
    bit          leap;
    mo   = (m == 0) ? 1 : ((m > 12) ? 12 : m);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    return CUM_DAYS[mo - 1] + d + ((mo > 2 && leap) ? 1 : 0);
  endfunction

  function automatic span_t predict_span(year_t fy, month_t fm, mday_t fd,
                                         year_t ty, month_t tm, mday_t td);
    longint unsigned start_num;
    longint unsigned end_num;
    longint unsigned diff;
    span_t           s;
    start_num = days_to_year(fy) + year_day(fy, fm, fd);
    end_num   = days_to_year(ty) + year_day(ty, tm, td);
    s.count   = '0;
    s.ok      = 1'b0;
    if (fy <= ty && end_num >= start_num) begin
      diff = end_num - start_num;
      if (diff > dbd_pkg::COUNT_MAX) begin
        diff = dbd_pkg::COUNT_MAX;
      end
      s.count = count_t'(diff);
      s.ok    = 1'b1;
    end
    return s;
  endfunction

  always @(posedge clk_i) begin
    span_t exp_span;
    if (!rst_ni) begin
      span_q.delete();
      err_cnt_o  = 0;
      pend_cnt_o = 0;
    end else begin
      // The block holds one item at a time, so a result never belongs to an
      // input transfer of the same edge.
      if (out_valid_i && out_ready_i) begin
        if (span_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: count %0d ok %0b",
                   $time, day_count_i, date_order_ok_i);
          err_cnt_o++;
        end else begin
          exp_span = span_q.pop_front();
          if (day_count_i !== exp_span.count) begin
            $display("%0t: day_count mismatch: expected %0d, actual %0d",
                     $time, exp_span.count, day_count_i);
            err_cnt_o++;
          end
          if (date_order_ok_i !== exp_span.ok) begin
            $display("%0t: date_order_ok mismatch: expected %0b, actual %0b",
                     $time, exp_span.ok, date_order_ok_i);
            err_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        span_q.push_back(predict_span(from_year_i, from_month_i, from_day_i,
                                      to_year_i, to_month_i, to_day_i));
      end
      pend_cnt_o = span_q.size();
    end
  end

endmodule

@@ bench/days_between_dates_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// days_between_dates_tb
// Feeds date pairs to the days-between-dates block with random gaps on both
// channels, a long output hold-off and a drain pause; the checker beside the
// block predicts every span and reports mismatches.
// ----------------------------------------------------------------------------
module days_between_dates_tb;

  typedef logic [dbd_pkg::YEAR_BITS-1:0]  year_t;
  typedef logic [dbd_pkg::MONTH_BITS-1:0] month_t;
  typedef logic [dbd_pkg::DAY_BITS-1:0]   mday_t;

  typedef struct packed {
    year_t  fy;
    month_t fm;
    mday_t  fd;
    year_t  ty;
    month_t tm;
    mday_t  td;
  } date_pair_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  year_t                             from_year_i    = '0;
  month_t                            from_month_i   = '0;
  mday_t                             from_day_i     = '0;
  year_t                             to_year_i      = '0;
  month_t                            to_month_i     = '0;
  mday_t                             to_day_i       = '0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic [dbd_pkg::COUNT_BITS-1:0]    day_count_o;
  logic                              date_order_ok_o;

  int err_cnt;
  int pend_cnt;
  int n_out     = 0;
  bit sink_free = 1'b0;

  days_between_dates u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .from_year_i     (from_year_i),
    .from_month_i    (from_month_i),
    .from_day_i      (from_day_i),
    .to_year_i       (to_year_i),
    .to_month_i      (to_month_i),
    .to_day_i        (to_day_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .day_count_o     (day_count_o),
    .date_order_ok_o (date_order_ok_o)
  );

  dbd_span_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .from_year_i     (from_year_i),
    .from_month_i    (from_month_i),
    .from_day_i      (from_day_i),
    .to_year_i       (to_year_i),
    .to_month_i      (to_month_i),
    .to_day_i        (to_day_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .day_count_i     (day_count_o),
    .date_order_ok_i (date_order_ok_o),
    .err_cnt_o       (err_cnt),
    .pend_cnt_o      (pend_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      n_out <= n_out + 1;
    end
  end

  function automatic date_pair_t mk_dates(int fy, int fm, int fd, int ty, int tm, int td);
    date_pair_t p;
    p.fy = year_t'(fy);
    p.fm = month_t'(fm);
    p.fd = mday_t'(fd);
    p.ty = year_t'(ty);
    p.tm = month_t'(tm);
    p.td = mday_t'(td);
    return p;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // The block sweeps one year per cycle, so most years stay small.
  function automatic year_t pick_year();
    if ($urandom_range(0, 99) < 8) begin
      return year_t'($urandom);
    end
    return year_t'($urandom_range(0, 300));
  endfunction

  function automatic mday_t valid_day(year_t y, month_t m);
    int unsigned dmax;
    bit          leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == 2) begin
      dmax = leap ? 29 : 28;
    end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
      dmax = 30;
    end else begin
      dmax = 31;
    end
    return mday_t'($urandom_range(1, dmax));
  endfunction

  function automatic date_pair_t rand_dates();
    date_pair_t p;
    year_t      tmp;
    int         kind;
    kind = $urandom_range(0, 99);
    p.ty = pick_year();
    if (kind < 15) begin
      // Any field value, out-of-range months and days included.
      p.fy = pick_year();
      p.fm = month_t'($urandom);
      p.fd = mday_t'($urandom);
      p.tm = month_t'($urandom);
      p.td = mday_t'($urandom);
    end else begin
      if (kind < 28) begin
        p.fy = pick_year();
        if (p.fy < p.ty) begin
          tmp  = p.fy;
          p.fy = p.ty;
          p.ty = tmp;
        end
      end else if (kind < 45) begin
        p.fy = p.ty;
      end else begin
        p.fy = year_t'($urandom_range(0, p.ty));
      end
      p.fm = month_t'($urandom_range(1, 12));
      p.tm = month_t'($urandom_range(1, 12));
      p.fd = valid_day(p.fy, p.fm);
      p.td = valid_day(p.ty, p.tm);
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(date_pair_t p);
    in_valid_i   <= 1'b1;
    from_year_i  <= p.fy;
    from_month_i <= p.fm;
    from_day_i   <= p.fd;
    to_year_i    <= p.ty;
    to_month_i   <= p.tm;
    to_day_i     <= p.td;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Output side: random stalls, plus one long hold-off once a few dozen
  // results have gone through, so the block stalls its input.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && n_out >= 60) begin
        held  = 1'b1;
        stall = 500;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!sink_free) begin
          stall = gap_len();
        end
      end
    end
  end

  initial begin
    date_pair_t dir_q [$];
    dir_q.push_back(mk_dates(1, 1, 1, 1, 1, 1));
    dir_q.push_back(mk_dates(0, 1, 1, 0, 12, 31));
    dir_q.push_back(mk_dates(0, 0, 0, 4095, 15, 31));
    dir_q.push_back(mk_dates(4095, 12, 31, 4095, 12, 31));
    dir_q.push_back(mk_dates(4095, 15, 31, 0, 0, 0));
    dir_q.push_back(mk_dates(2000, 1, 1, 1999, 12, 31));
    dir_q.push_back(mk_dates(2024, 3, 1, 2024, 2, 29));
    dir_q.push_back(mk_dates(1900, 2, 28, 1900, 3, 1));
    dir_q.push_back(mk_dates(2000, 2, 28, 2000, 3, 1));
    dir_q.push_back(mk_dates(2023, 0, 5, 2023, 13, 5));
    dir_q.push_back(mk_dates(2023, 14, 0, 2024, 15, 31));
    dir_q.push_back(mk_dates(2021, 2, 31, 2021, 3, 0));
    dir_q.push_back(mk_dates(1, 1, 1, 4095, 12, 31));
    dir_q.push_back(mk_dates(1365, 5, 10, 2730, 10, 21));
    dir_q.push_back(mk_dates(2730, 10, 21, 2730, 5, 10));
    dir_q.push_back(mk_dates(2400, 12, 31, 2401, 1, 1));
    dir_q.push_back(mk_dates(2100, 2, 29, 2100, 3, 1));
    dir_q.push_back(mk_dates(399, 12, 31, 400, 12, 31));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) begin
      send(dir_q[i]);
      idle(gap_len());
    end

    // A stretch with no idling on either side.
    sink_free = 1'b1;
    repeat (30) send(rand_dates());
    sink_free = 1'b0;

    // Let the block drain completely before going on.
    in_valid_i <= 1'b0;
    while (pend_cnt != 0) begin
      @(negedge clk_i);
    end

    repeat (92) begin
      send(rand_dates());
      idle(gap_len());
    end

    in_valid_i <= 1'b0;
    while (pend_cnt != 0) begin
      @(negedge clk_i);
    end
    // One full year sweep, in case a stray result follows.
    repeat (4100) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dbd_pkg.sv
hdl/days_between_dates.sv
bench/dbd_span_checker.sv
bench/days_between_dates_tb.sv
